// ===== rtl/mctf_pkg.sv =====
// Shared types and codes of the multichannel transmit ring FIFO.
`default_nettype none

package mctf_pkg;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  channel;
    logic [31:0] word_high;
    logic [31:0] word_low;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic [5:0]  served_channel;
    logic [31:0] out_high;
    logic [31:0] out_low;
    logic [63:0] served_mask;
    logic [31:0] lost_total;
    logic        last;
  } rsp_item_t;

  localparam logic [1:0] RK_PUSH_ACK = 2'd0;
  localparam logic [1:0] RK_WORD     = 2'd1;
  localparam logic [1:0] RK_EMPTY    = 2'd2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [5:0] CH_BCAST_ONCE  = 6'd63;
  localparam logic [5:0] CH_BCAST_TWICE = 6'd62;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BCAST,
    ST_POP_SCAN,
    ST_POP_EMIT,
    ST_ACK
  } state_t;

  // Command broadcast to every channel cell.
  typedef struct packed {
    logic push;
    logic pop;
    logic advance;
    logic clear;
  } cell_cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mctf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mctf_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mctf_cell.sv =====
// One channel cell: ring pointers and the sweep token passed to the next cell.
`default_nettype none

module mctf_cell #(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mctf_pkg::cell_cmd_t   cmd,
  input  wire logic                  direct,
  input  wire logic                  token_in,
  output logic                       token_out,
  output mctf_pkg::cell_stat_t       stat,
  output logic           [PTR_W-1:0] wptr,
  output logic           [PTR_W-1:0] rptr
);

  import mctf_pkg::*;

  logic             token;
  logic             act;
  logic [PTR_W-1:0] wptr_inc;
  logic [PTR_W-1:0] rptr_inc;

  assign wptr_inc = (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
  assign rptr_inc = (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;

  assign act           = token | direct;
  assign stat.full     = (wptr_inc == rptr);
  assign stat.nonempty = (wptr != rptr);
  assign token_out     = token;

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
      wptr  <= '0;
      rptr  <= '0;
    end else begin
      if (cmd.clear) begin
        token <= 1'b0;
      end else if (cmd.advance) begin
        token <= token_in;
      end
      // a full ring drops the word
      if (act && cmd.push && !stat.full) begin
        wptr <= wptr_inc;
      end
      if (act && cmd.pop) begin
        rptr <= rptr_inc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multichannel_tx_fifo_gather.sv =====
// Top level: row of channel cells, shared ring RAM and the request sequencer.
// Single push: accepted in the idle state, then the acknowledge is loaded from the ACK state.
// Broadcast: one cell per cycle along the token chain, over one sweep or two, then the acknowledge.
// Pop: accepted in the idle state, then each channel up to the last served one is skipped or served
// (RAM read, then output load); an empty pop goes straight to the acknowledge. Output stalls hold it.
// Reset clears pointers, tokens, lost counter and output valid; ring RAM is not cleared.
`default_nettype none

module multichannel_tx_fifo_gather #(
  parameter int CHANNELS = 16,
  parameter int DEPTH    = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire mctf_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output mctf_pkg::rsp_item_t      rsp
);

  import mctf_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = IDX_W + PTR_W;

  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic                second, second_next;
  logic [CHANNELS-1:0] mask, mask_next;
  logic [CHANNELS-1:0] pend_mask, pend_mask_next;
  logic [63:0]         word, word_next;
  logic [1:0]          ack_kind, ack_kind_next;
  logic                ack_acc, ack_acc_next;
  logic [31:0]         lost;
  logic                lost_inc;
  rsp_item_t           res_next;
  logic                load;
  logic                load_ok;

  cell_cmd_t           cmd;
  logic                token_start;
  logic [CHANNELS-1:0] direct;
  logic [CHANNELS-1:0] token_chain;
  cell_stat_t          stat [CHANNELS];
  logic [PTR_W-1:0]    wptr_arr [CHANNELS];
  logic [PTR_W-1:0]    rptr_arr [CHANNELS];
  logic [CHANNELS-1:0] full_vec;
  logic [CHANNELS-1:0] nonempty_vec;

  logic [IDX_W-1:0]    sel_idx;
  logic                full_sel;
  logic [PTR_W-1:0]    wptr_sel;
  logic [PTR_W-1:0]    rptr_sel;
  logic                ch_ok;
  logic                direct_en;

  logic                mem_we;
  logic                mem_re;
  logic [63:0]         mem_wdata;
  logic [63:0]         mem_rdata;

  // Channel cells
  for (genvar c = 0; c < CHANNELS; c++) begin : g_cell
    logic tok_in;
    if (c == 0) begin : g_head
      assign tok_in = token_start;
    end else begin : g_link
      assign tok_in = token_chain[c-1];
    end

    assign direct[c]       = direct_en && (req.channel == 6'(c));
    assign full_vec[c]     = stat[c].full;
    assign nonempty_vec[c] = stat[c].nonempty;

    mctf_cell #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .direct    (direct[c]),
      .token_in  (tok_in),
      .token_out (token_chain[c]),
      .stat      (stat[c]),
      .wptr      (wptr_arr[c]),
      .rptr      (rptr_arr[c])
    );
  end

  mctf_ram #(
    .WIDTH  (64),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({sel_idx, wptr_sel}),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr ({sel_idx, rptr_sel}),
    .rdata (mem_rdata)
  );

  assign req_stall = (state != ST_IDLE);
  assign load_ok   = !rsp_valid || !rsp_stall;
  assign ch_ok     = (req.channel < 6'(CHANNELS));
  assign sel_idx   = (state == ST_IDLE) ? req.channel[IDX_W-1:0] : idx;
  assign full_sel  = full_vec[sel_idx];
  assign wptr_sel  = wptr_arr[sel_idx];
  assign rptr_sel  = rptr_arr[sel_idx];
  assign mem_wdata = (state == ST_IDLE) ? {req.word_high, req.word_low} : word;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    second_next    = second;
    mask_next      = mask;
    pend_mask_next = pend_mask;
    word_next      = word;
    ack_kind_next  = ack_kind;
    ack_acc_next   = ack_acc;
    cmd            = '0;
    token_start    = 1'b0;
    direct_en      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    lost_inc       = 1'b0;
    load           = 1'b0;
    res_next       = '0;
    res_next.lost_total = lost;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.req_type == REQ_PUSH) begin
            ack_kind_next = RK_PUSH_ACK;
            if (ch_ok) begin
              direct_en    = 1'b1;
              cmd.push     = 1'b1;
              mem_we       = !full_sel;
              lost_inc     = full_sel;
              ack_acc_next = !full_sel;
              state_next   = ST_ACK;
            end else if (req.channel == CH_BCAST_ONCE || req.channel == CH_BCAST_TWICE) begin
              token_start  = 1'b1;
              cmd.advance  = 1'b1;
              second_next  = (req.channel == CH_BCAST_TWICE);
              idx_next     = '0;
              word_next    = {req.word_high, req.word_low};
              ack_acc_next = 1'b1;
              state_next   = ST_BCAST;
            end else begin
              ack_acc_next = 1'b0;
              state_next   = ST_ACK;
            end
          end else begin
            // snapshot which rings hold data at the start of the pop
            mask_next      = nonempty_vec;
            pend_mask_next = nonempty_vec;
            if (nonempty_vec == '0) begin
              ack_kind_next = RK_EMPTY;
              ack_acc_next  = 1'b1;
              state_next    = ST_ACK;
            end else begin
              token_start = 1'b1;
              cmd.advance = 1'b1;
              idx_next    = '0;
              state_next  = ST_POP_SCAN;
            end
          end
        end
      end
      ST_BCAST: begin
        cmd.push    = 1'b1;
        cmd.advance = 1'b1;
        mem_we      = !full_sel;
        lost_inc    = full_sel;
        if (idx == IDX_W'(CHANNELS - 1)) begin
          idx_next = '0;
          if (second) begin
            // relaunch the token for the second sweep
            token_start = 1'b1;
            second_next = 1'b0;
          end else begin
            cmd.clear  = 1'b1;
            state_next = ST_ACK;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_POP_SCAN: begin
        if (pend_mask[idx]) begin
          cmd.pop             = 1'b1;
          mem_re              = 1'b1;
          pend_mask_next[idx] = 1'b0;
          state_next          = ST_POP_EMIT;
        end else begin
          cmd.advance = 1'b1;
          idx_next    = idx + 1'b1;
        end
      end
      ST_POP_EMIT: begin
        if (load_ok) begin
          load                    = 1'b1;
          res_next.result_kind    = RK_WORD;
          res_next.accepted       = 1'b1;
          res_next.served_channel = 6'(idx);
          res_next.out_high       = mem_rdata[63:32];
          res_next.out_low        = mem_rdata[31:0];
          res_next.served_mask    = 64'(mask);
          res_next.last           = (pend_mask == '0);
          if (pend_mask == '0) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            idx_next    = idx + 1'b1;
            state_next  = ST_POP_SCAN;
          end
        end
      end
      ST_ACK: begin
        if (load_ok) begin
          load                 = 1'b1;
          res_next.result_kind = ack_kind;
          res_next.accepted    = ack_acc;
          res_next.last        = 1'b1;
          state_next           = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      second    <= 1'b0;
      lost      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      second <= second_next;
      if (lost_inc) begin
        lost <= lost + 1'b1;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mask      <= mask_next;
    pend_mask <= pend_mask_next;
    word      <= word_next;
    ack_kind  <= ack_kind_next;
    ack_acc   <= ack_acc_next;
    if (load) begin
      rsp <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mctf_checker.sv =====
// Port-level checker for the multichannel transmit ring FIFO, bound to the top level.
`default_nettype none

module mctf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_stall,
  input wire mctf_pkg::req_item_t req,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire mctf_pkg::rsp_item_t rsp
);

  import mctf_pkg::*;

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("request dropped or changed while stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  a_ack_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RK_PUSH_ACK |-> rsp.last && rsp.served_mask == '0)
    else $error("push acknowledge must be a single result with empty mask");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RK_EMPTY |->
      rsp.last && rsp.accepted && rsp.served_mask == '0)
    else $error("empty pop result malformed");

  a_word_in_mask: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_kind == RK_WORD |->
      rsp.accepted && rsp.served_mask[rsp.served_channel])
    else $error("popped channel missing from served mask");

endmodule

bind multichannel_tx_fifo_gather mctf_checker u_mctf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
